[rtl/core/olke_pkg.sv]
// Shared constants, codes, types and helpers for the ordered list key engine.
// Used by olke_ctrl, olke_dp and the top level in rtl/core; depends on nothing.
package olke_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OP_W      = 3;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;

    localparam int IN_BITS   = OP_W + DATA_W;
    localparam int OUT_BITS  = STATUS_W + DATA_W + IDX_W + CNT_W + 1;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - OUT_BITS;

    // Operation codes; the remaining codes are accepted and leave the list alone
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_KEY   = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LINK,
        S_INSERT,
        S_WALK,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic dispatch;
        logic link_tail;
        logic insert;
        logic walk;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_insert;
        logic is_back;
        logic is_search;
        logic empty;
        logic full;
        logic hit;
        logic last;
        logic out_free;
    } stat_t;

    // Lowest-numbered free slot; zero when none is free
    function automatic logic [IDX_W-1:0] first_free(input logic [CAPACITY-1:0] free_map);
        logic [IDX_W-1:0] slot;
        slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (free_map[i]) begin
                slot = IDX_W'(i);
            end
        end
        return slot;
    endfunction

endpackage

[rtl/core/olke_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the entry values and the next links of the list.
module olke_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/olke_ctrl.sv]
// Sequencing state machine for the ordered list key engine.
// Depends on olke_pkg; drives the datapath olke_dp through cmd_t and reads stat_t.
module olke_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  olke_pkg::stat_t stat,
    output olke_pkg::cmd_t  cmd
);
    import olke_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.is_insert) begin
                    if (stat.full) begin
                        state_next = S_FINISH;
                    end else if (stat.is_back && !stat.empty) begin
                        state_next = S_LINK;
                    end else begin
                        state_next = S_INSERT;
                    end
                end else if (stat.is_search && !stat.empty) begin
                    state_next = S_WALK;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_LINK:   state_next = S_INSERT;
            S_INSERT: state_next = S_FINISH;
            S_WALK: begin
                if (stat.hit || stat.last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == S_IDLE);
        cmd           = '0;
        cmd.capture   = (state_reg == S_IDLE) && s_tvalid;
        cmd.dispatch  = (state_reg == S_DISPATCH);
        cmd.link_tail = (state_reg == S_LINK);
        cmd.insert    = (state_reg == S_INSERT);
        cmd.walk      = (state_reg == S_WALK);
        cmd.finish    = (state_reg == S_FINISH) && stat.out_free;
    end

endmodule

[rtl/core/olke_dp.sv]
// Datapath of the ordered list key engine: slot stores, list registers, walk
// and result register. Depends on olke_pkg and olke_ram; steered by olke_ctrl.
module olke_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [olke_pkg::OP_W-1:0]         in_op,
    input  logic signed [olke_pkg::DATA_W-1:0] in_value,
    input  olke_pkg::cmd_t                    cmd,
    output olke_pkg::stat_t                   stat,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output olke_pkg::status_t                 res_status,
    output logic signed [olke_pkg::DATA_W-1:0] res_removed,
    output logic [olke_pkg::IDX_W-1:0]        res_position,
    output logic [olke_pkg::CNT_W-1:0]        res_count,
    output logic                              res_empty
);
    import olke_pkg::*;

    // List state
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAPACITY-1:0] free_reg, free_next;

    // Request and walk state
    logic [OP_W-1:0]          op_reg, op_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]         cur_reg, cur_next;
    logic [IDX_W-1:0]         prev_reg, prev_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    status_t                  status_reg, status_next;

    // Result register
    logic                     m_valid_reg, m_valid_next;
    status_t                  res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] res_removed_reg, res_removed_next;
    logic [IDX_W-1:0]         res_pos_reg, res_pos_next;
    logic [CNT_W-1:0]         res_count_reg, res_count_next;
    logic                     res_empty_reg, res_empty_next;

    // Memory ports
    logic [DATA_W-1:0] entry_rdata;
    logic [IDX_W-1:0]  link_rdata;
    logic              link_we;
    logic [IDX_W-1:0]  link_waddr, link_wdata;

    logic [IDX_W-1:0] slot;
    logic             hit, last, is_search, is_rem_front, do_remove;
    logic [CNT_W-1:0] idx_inc;

    assign slot         = first_free(free_reg);
    assign hit          = (entry_rdata == val_reg);
    assign idx_inc      = CNT_W'(idx_reg) + CNT_W'(1);
    assign last         = (idx_inc == count_reg);
    assign is_search    = (op_reg == OP_FIND) || (op_reg == OP_REM_KEY);
    assign is_rem_front = (op_reg == OP_REM_FRONT);
    assign do_remove    = (is_rem_front || (op_reg == OP_REM_KEY)) && (status_reg == ST_OK);

    always_comb begin
        stat           = '0;
        stat.is_insert = (op_reg == OP_INS_FRONT) || (op_reg == OP_INS_BACK);
        stat.is_back   = (op_reg == OP_INS_BACK);
        stat.is_search = is_search;
        stat.empty     = (count_reg == '0);
        stat.full      = (count_reg == CNT_W'(CAPACITY));
        stat.hit       = hit;
        stat.last      = last;
        stat.out_free  = !m_valid_reg || m_tready;
    end

    // Read address tracks cur_next so the store outputs always show slot cur_reg
    always_comb begin
        cur_next = cur_reg;
        if (cmd.capture) begin
            cur_next = head_reg;
        end else if (cmd.walk && !hit && !last) begin
            cur_next = link_rdata;
        end
    end

    always_comb begin
        link_we    = 1'b0;
        link_waddr = slot;
        link_wdata = slot;
        if (cmd.link_tail) begin
            link_we    = 1'b1;
            link_waddr = tail_reg;
        end
        if (cmd.insert) begin
            link_we    = 1'b1;
            link_wdata = (op_reg == OP_INS_FRONT) ? head_reg : slot;
        end
        if (cmd.finish && do_remove && (op_reg == OP_REM_KEY) && (idx_reg != '0)) begin
            link_we    = 1'b1;
            link_waddr = prev_reg;
            link_wdata = link_rdata;
        end
    end

    olke_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_entry_ram (
        .aclk  (aclk),
        .we    (cmd.insert),
        .waddr (slot),
        .wdata (val_reg),
        .raddr (cur_next),
        .rdata (entry_rdata)
    );

    olke_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (cur_next),
        .rdata (link_rdata)
    );

    always_comb begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        free_next        = free_reg;
        op_next          = op_reg;
        val_next         = val_reg;
        prev_next        = prev_reg;
        idx_next         = idx_reg;
        status_next      = status_reg;
        m_valid_next     = m_valid_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        res_pos_next     = res_pos_reg;
        res_count_next   = res_count_reg;
        res_empty_next   = res_empty_reg;

        if (cmd.capture) begin
            op_next     = in_op;
            val_next    = in_value;
            prev_next   = head_reg;
            idx_next    = '0;
            status_next = ST_OK;
        end

        if (cmd.dispatch) begin
            if (stat.is_insert && stat.full) begin
                status_next = ST_FULL;
            end else if ((is_search || is_rem_front) && stat.empty) begin
                status_next = ST_EMPTY;
            end
        end

        // One linked entry per cycle
        if (cmd.walk && !hit) begin
            if (last) begin
                status_next = ST_NOT_FOUND;
            end else begin
                prev_next = cur_reg;
                idx_next  = idx_reg + IDX_W'(1);
            end
        end

        if (cmd.insert) begin
            free_next[slot] = 1'b0;
            count_next      = count_reg + CNT_W'(1);
            if (op_reg == OP_INS_FRONT) begin
                head_next = slot;
                if (stat.empty) begin
                    tail_next = slot;
                end
            end else begin
                tail_next = slot;
                if (stat.empty) begin
                    head_next = slot;
                end
            end
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.finish) begin
            if (do_remove) begin
                free_next[cur_reg] = 1'b1;
                count_next         = count_reg - CNT_W'(1);
                if (idx_reg == '0) begin
                    head_next = link_rdata;
                end else if (last) begin
                    tail_next = prev_reg;
                end
                if (count_reg == CNT_W'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end
            end
            m_valid_next     = 1'b1;
            res_status_next  = status_reg;
            res_removed_next = (is_rem_front && (status_reg == ST_OK)) ? entry_rdata : '0;
            res_pos_next     = (is_search && (status_reg == ST_OK)) ? idx_reg : '0;
            res_count_next   = count_next;
            res_empty_next   = (count_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            free_reg    <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        val_reg         <= val_next;
        cur_reg         <= cur_next;
        prev_reg        <= prev_next;
        idx_reg         <= idx_next;
        status_reg      <= status_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        res_pos_reg     <= res_pos_next;
        res_count_reg   <= res_count_next;
        res_empty_reg   <= res_empty_next;
    end

    assign m_tvalid     = m_valid_reg;
    assign res_status   = res_status_reg;
    assign res_removed  = res_removed_reg;
    assign res_position = res_pos_reg;
    assign res_count    = res_count_reg;
    assign res_empty    = res_empty_reg;

    // Every slot is either free or held by the list
    a_slot_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(free_reg) + int'(count_reg)) == CAPACITY)
        else $error("free map and entry count disagree");

    a_empty_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> ((head_reg == '0) && (tail_reg == '0)))
        else $error("empty list with head or tail away from slot zero");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid_reg)
        else $error("finished request left no result");

endmodule

[rtl/core/ordered_list_key_engine.sv]
// Top level of the ordered list key engine: stream ports, field packing,
// controller and datapath. Depends on olke_pkg, olke_ctrl, olke_dp, olke_ram.
//
// A bounded singly linked list of up to 16 signed 32-bit values. Each request
// carries an operation (insert front, insert back, remove front, find key,
// remove key) and a value, and gives exactly one result: status (ok, key not
// found, list empty, list full), the value taken on remove front, the position
// from the front of a matched key, the entry count afterwards and an empty flag.
// New entries take the lowest free slot. Requests are served one at a time:
// remove front, refused inserts, requests on an empty list and unused codes
// go straight from dispatch to the result, inserts pass an insert step, insert
// back on a non-empty list first takes a link step, and find or remove key walk
// along the next links, reading one entry per cycle from the slot stores through
// their single read port. A new request is taken as soon as the previous result
// has been loaded into the output register, even while that result still waits
// on m_tready.
module ordered_list_key_engine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // operation [2:0], value [34:3], zero fill above
    input  logic [olke_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status [1:0], removed_value [33:2], position [37:34],
    // entry_count [42:38], list_empty [43], zero fill above
    output logic [olke_pkg::M_TDATA_W-1:0]   m_tdata
);
    import olke_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic [OP_W-1:0]          in_op;
    logic signed [DATA_W-1:0] in_value;

    status_t                  res_status;
    logic signed [DATA_W-1:0] res_removed;
    logic [IDX_W-1:0]         res_position;
    logic [CNT_W-1:0]         res_count;
    logic                     res_empty;

    // Unpack the request; fill bits above the fields are dropped
    assign in_op    = s_tdata[OP_W-1:0];
    assign in_value = s_tdata[OP_W +: DATA_W];

    olke_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    olke_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_op        (in_op),
        .in_value     (in_value),
        .cmd          (cmd),
        .stat         (stat),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .res_status   (res_status),
        .res_removed  (res_removed),
        .res_position (res_position),
        .res_count    (res_count),
        .res_empty    (res_empty)
    );

    // Pack the result, first field lowest, zero fill to whole bytes
    assign m_tdata = {{M_PAD_W{1'b0}}, res_empty, res_count, res_position,
                      res_removed, res_status};

endmodule

[verif/olke_checker.sv]
// Checker for the ordered list key engine: watches both stream channels, predicts
// each result from the requests it sees and compares them field by field.
// Depends on olke_pkg for widths, operation codes and status codes.
module olke_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [olke_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [olke_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             fail_count,
    output int                             outstanding,
    output int                             hits_seen,
    output int                             misses_seen,
    output int                             empty_seen,
    output int                             full_seen,
    output int                             peak_depth
);
    timeunit 1ns;
    timeprecision 1ps;
    import olke_pkg::*;

    localparam int POS_LSB   = STATUS_W + DATA_W;
    localparam int CNT_LSB   = POS_LSB + IDX_W;
    localparam int EMPTY_BIT = CNT_LSB + CNT_W;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] removed;
        logic [IDX_W-1:0]  position;
        logic [CNT_W-1:0]  count;
        logic              empty;
    } list_outcome_t;

    // list contents, front first; slot numbers never show at the ports
    logic [DATA_W-1:0] held_values[$];
    list_outcome_t     expected_outcomes[$];

    function automatic list_outcome_t apply_list_op(input logic [OP_W-1:0] op,
                                                    input logic [DATA_W-1:0] key);
        list_outcome_t r;
        int            at;
        r = '0;
        r.status = ST_OK;
        at = -1;
        case (op)
            OP_INS_FRONT, OP_INS_BACK: begin
                if (held_values.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (op == OP_INS_FRONT) begin
                    held_values.push_front(key);
                end else begin
                    held_values.push_back(key);
                end
            end
            OP_REM_FRONT: begin
                if (held_values.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = held_values.pop_front();
                end
            end
            OP_FIND, OP_REM_KEY: begin
                if (held_values.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < held_values.size(); i++) begin
                        if (held_values[i] == key) begin
                            at = i;
                            break;
                        end
                    end
                    if (at < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.position = IDX_W'(at);
                        if (op == OP_REM_KEY) begin
                            held_values.delete(at);
                        end
                    end
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(held_values.size());
        r.empty = (held_values.size() == 0);
        return r;
    endfunction

    always @(posedge aclk) begin
        list_outcome_t want;
        list_outcome_t got;
        if (!aresetn) begin
            held_values.delete();
            expected_outcomes.delete();
        end else begin
            // results first: the oldest expectation always belongs to an earlier request
            if (m_tvalid && m_tready) begin
                got.status   = status_t'(m_tdata[STATUS_W-1:0]);
                got.removed  = m_tdata[STATUS_W +: DATA_W];
                got.position = m_tdata[POS_LSB +: IDX_W];
                got.count    = m_tdata[CNT_LSB +: CNT_W];
                got.empty    = m_tdata[EMPTY_BIT];
                if (expected_outcomes.size() == 0) begin
                    if (fail_count < REPORT_MAX) begin
                        $display("%0t: result with no request waiting: status %0d count %0d",
                                 $realtime, got.status, got.count);
                    end
                    fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got != want) begin
                        if (fail_count < REPORT_MAX) begin
                            $display({"%0t: mismatch status %0d/%0d removed %h/%h ",
                                      "position %0d/%0d count %0d/%0d empty %0b/%0b ",
                                      "(expected/actual)"},
                                     $realtime, want.status, got.status,
                                     want.removed, got.removed, want.position,
                                     got.position, want.count, got.count,
                                     want.empty, got.empty);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = apply_list_op(s_tdata[OP_W-1:0], s_tdata[OP_W +: DATA_W]);
                expected_outcomes.push_back(want);
                case (want.status)
                    ST_NOT_FOUND: misses_seen++;
                    ST_EMPTY:     empty_seen++;
                    ST_FULL:      full_seen++;
                    default: begin
                        if (s_tdata[OP_W-1:0] == OP_FIND || s_tdata[OP_W-1:0] == OP_REM_KEY) begin
                            hits_seen++;
                        end
                    end
                endcase
                if (int'(want.count) > peak_depth) begin
                    peak_depth = int'(want.count);
                end
            end
        end
        outstanding = expected_outcomes.size();
    end

endmodule

[verif/ordered_list_key_engine_test.sv]
// Testbench top for the ordered list key engine: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on olke_pkg, olke_checker and the RTL.
module ordered_list_key_engine_test;
    timeunit 1ns;
    timeprecision 1ps;
    import olke_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_STALL   = 300;   // receiver hold-off, in cycles
    localparam int SETTLE_TIME  = 40;    // longer than the slowest key walk
    localparam int STALL_AT     = 500;
    localparam int DRAIN_AT     = 900;

    // codes the block accepts and ignores
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int hits_seen;
    int misses_seen;
    int empty_seen;
    int full_seen;
    int peak_depth;

    int   cycle_count = 0;
    int   requests_sent = 0;
    logic steady = 1'b0;          // both sides run without gaps while set
    logic stall_request = 1'b0;
    logic stall_done = 1'b0;

    // keys: the extremes, alternating bit patterns and a few random values, so that
    // finds and key removals hit often and duplicates turn up
    logic [DATA_W-1:0] key_pool[16];

    ordered_list_key_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    olke_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .hits_seen   (hits_seen),
        .misses_seen (misses_seen),
        .empty_seen  (empty_seen),
        .full_seen   (full_seen),
        .peak_depth  (peak_depth)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Abandon a hung run
    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Bias towards inserts while growing and towards removals while shrinking,
    // so the list swings between empty and full
    function automatic logic [OP_W-1:0] pick_op(input logic growing);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        if (growing) begin
            if (r < 35) return OP_INS_FRONT;
            if (r < 65) return OP_INS_BACK;
            if (r < 75) return OP_REM_FRONT;
            if (r < 88) return OP_FIND;
            return OP_REM_KEY;
        end
        if (r < 15) return OP_INS_FRONT;
        if (r < 30) return OP_INS_BACK;
        if (r < 60) return OP_REM_FRONT;
        if (r < 75) return OP_FIND;
        return OP_REM_KEY;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 75) return key_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    // Present one request from the falling edge and hold it until accepted
    task automatic offer(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({value, op});
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    // Drop valid for the given number of cycles
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin : result_sink
        int gap;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (stall_request && !stall_done) begin
                // hold ready low long enough for the block to back up into its input
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(negedge aclk);
                stall_done = 1'b1;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        logic growing;
        int   phase_left;
        int   directed_count;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        key_pool[4] = 32'h5555_5555;
        key_pool[5] = 32'haaaa_aaaa;
        for (int i = 6; i < 16; i++) begin
            key_pool[i] = $urandom;
        end
        growing    = 1'b1;
        phase_left = 0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every removal and search on an empty list
        offer(OP_REM_FRONT, key_pool[1]);
        offer(OP_FIND, key_pool[0]);
        offer(OP_REM_KEY, key_pool[0]);
        // ignored codes leave the list alone
        for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) begin
            offer(OP_W'(c), key_pool[3]);
        end
        // fill to capacity from both ends, extremes first
        for (int i = 0; i < CAPACITY; i++) begin
            offer(i[0] ? OP_INS_FRONT : OP_INS_BACK, key_pool[i]);
        end
        // refuse inserts when full
        offer(OP_INS_FRONT, key_pool[2]);
        offer(OP_INS_BACK, key_pool[2]);
        // find the tail entry at the last position, then miss
        offer(OP_FIND, key_pool[14]);
        offer(OP_FIND, 32'h1357_9bdf);
        // remove the tail by key, then the head by key, then a middle entry
        offer(OP_REM_KEY, key_pool[14]);
        offer(OP_REM_KEY, key_pool[15]);
        offer(OP_REM_KEY, key_pool[4]);
        offer(OP_REM_FRONT, key_pool[0]);
        directed_count = requests_sent;

        // Random: defined operations and the occasional spare code, on a list that grows and shrinks in phases
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                growing    = ~growing;
                phase_left = $urandom_range(15, 70);
            end
            phase_left--;
            if (n % 200 == 100) begin
                steady = ~steady;
            end
            if (n == STALL_AT) begin
                stall_request = 1'b1;
            end
            offer(pick_op(growing), pick_value());
            if (n == DRAIN_AT) begin
                // pause until every result is out, then carry on from an idle block
                idle_sender(1);
                while (outstanding != 0) @(negedge aclk);
            end else if (!(stall_request && !stall_done)) begin
                idle_sender(pick_gap());
            end
        end

        // Let the last results out and watch for strays
        steady = 1'b0;
        idle_sender(1);
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_TIME) @(negedge aclk);

        $display("Covered %0d requests (%0d directed): %0d key hits, %0d misses,",
                 requests_sent, directed_count, hits_seen, misses_seen);
        $display("  %0d on an empty list, %0d refused when full, up to %0d entries held.",
                 empty_seen, full_seen, peak_depth);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
